[rtl/extended_gcd_modular_inverse_assert.svh]
// assertion macros for the extended gcd block
`ifndef EXTENDED_GCD_MODULAR_INVERSE_ASSERT_SVH
`define EXTENDED_GCD_MODULAR_INVERSE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define EGCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define EGCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/egcd_pkg.sv]
// shared constants and status codes for the extended gcd block
package egcd_pkg;

	localparam int OPND_W    = 31;
	localparam int COEF_W    = 32;
	localparam int ACC_W     = 34;
	localparam int SHIFT_W   = 5;
	localparam int DEF_WIDTH = 32;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_NO_INV = 2'd1,
		STATUS_ZERO   = 2'd2
	} status_t;

endpackage

[rtl/extended_gcd_modular_inverse.sv]
// extended euclid with bezout coefficients and modular inverse, top level
// a zero operand goes straight to the result; otherwise each euclid step aligns
// the divisor by shifting, then subtracts and shifts back one quotient bit at a
// time, all on the single subtract and shift unit
// the block takes no new item while busy with one; the next transfer is taken
// while a finished result still waits; reset returns to idle with no result
module extended_gcd_modular_inverse
	import egcd_pkg::*;
#(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [OPND_W-1:0]        operand_a,
	input  logic [OPND_W-1:0]        operand_b,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [OPND_W-1:0]        gcd_value,
	output logic signed [COEF_W-1:0] coef_a,
	output logic signed [COEF_W-1:0] coef_b,
	output logic [OPND_W-1:0]        inverse,
	output logic [1:0]               status
);

	localparam int STEP_CAP = 2 * WIDTH + 2;
	localparam int STEP_W   = $clog2(STEP_CAP + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ALIGN,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                    state_q;
	logic [OPND_W-1:0]         r0_q, r1_q, b_q;
	logic [OPND_W:0]           d_q;
	logic signed [ACC_W-1:0]   s0_q, s1_q, t0_q, t1_q, ms_q, mt_q;
	logic [SHIFT_W-1:0]        k_q;
	logic [STEP_W-1:0]         step_q;
	logic                      a_div_q, zero_q;
	logic                      out_valid_q;
	logic [OPND_W-1:0]         gcd_q, inv_q;
	logic signed [COEF_W-1:0]  ca_q, cb_q;
	status_t                   status_q;

	logic [OPND_W:0]           rem_ext, d_dbl, rem_sub;
	logic                      ge;
	logic [OPND_W-1:0]         rem_n;
	logic signed [ACC_W-1:0]   s0_n, t0_n, ca_full, cb_full;
	logic signed [COEF_W-1:0]  ca, cb;
	logic [COEF_W-1:0]         inv_sum;

	assign rem_ext = {1'b0, r0_q};
	assign d_dbl   = {d_q[OPND_W-1:0], 1'b0};
	assign ge      = rem_ext >= d_q;
	assign rem_sub = rem_ext - d_q;
	assign rem_n   = ge ? rem_sub[OPND_W-1:0] : r0_q;
	assign s0_n    = ge ? s0_q - ms_q : s0_q;
	assign t0_n    = ge ? t0_q - mt_q : t0_q;

	assign ca_full = a_div_q ? s0_q : t0_q;
	assign cb_full = a_div_q ? t0_q : s0_q;
	assign ca      = ca_full[COEF_W-1:0];
	assign cb      = cb_full[COEF_W-1:0];
	assign inv_sum = ca[COEF_W-1] ? (COEF_W'(ca) + {1'b0, b_q}) : COEF_W'(ca);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			r0_q        <= '0;
			r1_q        <= '0;
			b_q         <= '0;
			d_q         <= '0;
			s0_q        <= '0;
			s1_q        <= '0;
			t0_q        <= '0;
			t1_q        <= '0;
			ms_q        <= '0;
			mt_q        <= '0;
			k_q         <= '0;
			step_q      <= '0;
			a_div_q     <= 1'b0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
			gcd_q       <= '0;
			inv_q       <= '0;
			ca_q        <= '0;
			cb_q        <= '0;
			status_q    <= STATUS_OK;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						b_q     <= operand_b;
						a_div_q <= operand_a > operand_b;
						r0_q    <= (operand_a > operand_b) ? operand_a : operand_b;
						r1_q    <= (operand_a > operand_b) ? operand_b : operand_a;
						s0_q    <= ACC_W'(1);
						s1_q    <= '0;
						t0_q    <= '0;
						t1_q    <= ACC_W'(1);
						step_q  <= '0;
						zero_q  <= (operand_a == '0) || (operand_b == '0);
						state_q <= ((operand_a == '0) || (operand_b == '0)) ? ST_FIN : ST_CHECK;
					end
				end
				ST_CHECK: begin
					if ((r1_q == '0) || (step_q == STEP_W'(STEP_CAP))) begin
						state_q <= ST_FIN;
					end else begin
						d_q     <= {1'b0, r1_q};
						ms_q    <= s1_q;
						mt_q    <= t1_q;
						k_q     <= '0;
						state_q <= ST_ALIGN;
					end
				end
				ST_ALIGN: begin
					if (d_dbl <= rem_ext) begin
						d_q  <= d_dbl;
						ms_q <= ms_q <<< 1;
						mt_q <= mt_q <<< 1;
						k_q  <= k_q + SHIFT_W'(1);
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (k_q == '0) begin
						r0_q    <= r1_q;
						r1_q    <= rem_n;
						s0_q    <= s1_q;
						s1_q    <= s0_n;
						t0_q    <= t1_q;
						t1_q    <= t0_n;
						step_q  <= step_q + STEP_W'(1);
						state_q <= ST_CHECK;
					end else begin
						r0_q <= rem_n;
						s0_q <= s0_n;
						t0_q <= t0_n;
						d_q  <= d_q >> 1;
						ms_q <= ms_q >>> 1;
						mt_q <= mt_q >>> 1;
						k_q  <= k_q - SHIFT_W'(1);
					end
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						if (zero_q) begin
							gcd_q    <= '0;
							ca_q     <= '0;
							cb_q     <= '0;
							inv_q    <= '0;
							status_q <= STATUS_ZERO;
						end else begin
							gcd_q    <= r0_q;
							ca_q     <= ca;
							cb_q     <= cb;
							inv_q    <= inv_sum[OPND_W-1:0];
							status_q <= (r0_q == OPND_W'(1)) ? STATUS_OK : STATUS_NO_INV;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign gcd_value = gcd_q;
	assign coef_a    = ca_q;
	assign coef_b    = cb_q;
	assign inverse   = inv_q;
	assign status    = status_q;

endmodule

[rtl/egcd_chk.sv]
// port-level checker for the extended gcd block and its bind
`include "extended_gcd_modular_inverse_assert.svh"

module egcd_chk
	import egcd_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [OPND_W-1:0]        operand_a,
	input logic [OPND_W-1:0]        operand_b,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [OPND_W-1:0]        gcd_value,
	input logic signed [COEF_W-1:0] coef_a,
	input logic signed [COEF_W-1:0] coef_b,
	input logic [OPND_W-1:0]        inverse,
	input logic [1:0]               status
);

	logic                            in_xfer, zero_res, ok_res, live_res;
	logic                            zero_fields, unit_gcd, live_fields;
	logic [2*OPND_W+2*COEF_W+1:0]    out_bus;

	assign in_xfer     = in_valid && !in_stall;
	assign zero_res    = out_valid && (status == STATUS_ZERO);
	assign ok_res      = out_valid && (status == STATUS_OK);
	assign live_res    = out_valid && (status != STATUS_ZERO);
	assign zero_fields = (gcd_value == '0) && (coef_a == '0) && (coef_b == '0)
		&& (inverse == '0);
	assign unit_gcd    = gcd_value == OPND_W'(1);
	assign live_fields = (gcd_value != '0)
		&& ((status == STATUS_OK) || (status == STATUS_NO_INV));
	assign out_bus     = {gcd_value, coef_a, coef_b, inverse, status};

	`EGCD_ASSERT_NEXT(a_busy_after_transfer, in_xfer, in_stall, "accepted item left block idle")
	`EGCD_ASSERT_NOW(a_zero_fields, zero_res, zero_fields, "zero operand result has nonzero fields")
	`EGCD_ASSERT_NOW(a_ok_means_unit_gcd, ok_res, unit_gcd, "ok status without unit gcd")
	`EGCD_ASSERT_NOW(a_gcd_nonzero, live_res, live_fields, "bad gcd or status code")
	`EGCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bus), "stalled result changed")

endmodule

bind extended_gcd_modular_inverse egcd_chk u_egcd_chk (.*);

[bench/tb_extended_gcd_modular_inverse.sv]
// self-checking testbench for the extended gcd and modular inverse block
module tb_extended_gcd_modular_inverse;
	import egcd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEP_CAP = 2 * DEF_WIDTH + 2;
	localparam logic [OPND_W-1:0] OPND_MAX = {OPND_W{1'b1}};

	typedef struct {
		logic [OPND_W-1:0] a;
		logic [OPND_W-1:0] b;
	} operand_pair_t;

	typedef struct {
		logic [OPND_W-1:0]        gcd;
		logic signed [COEF_W-1:0] ca;
		logic signed [COEF_W-1:0] cb;
		logic [OPND_W-1:0]        inv;
		status_t                  st;
	} bezout_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [OPND_W-1:0]        operand_a = '0;
	logic [OPND_W-1:0]        operand_b = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [OPND_W-1:0]        gcd_value;
	logic signed [COEF_W-1:0] coef_a;
	logic signed [COEF_W-1:0] coef_b;
	logic [OPND_W-1:0]        inverse;
	logic [1:0]               status;

	operand_pair_t  operand_q[$];
	bezout_result_t bezout_expect_q[$];

	int  sender_idle_pct = 0;
	int  receiver_stall_pct = 0;
	int  hold_req = 0;
	int  hold_cnt = 0;
	int  errors = 0;
	int  n_in = 0;
	int  n_out = 0;
	int  n_ok = 0;
	int  n_no_inv = 0;
	int  n_zero = 0;
	logic in_taken = 1'b0;

	extended_gcd_modular_inverse dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.gcd_value (gcd_value),
		.coef_a    (coef_a),
		.coef_b    (coef_b),
		.inverse   (inverse),
		.status    (status)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic bezout_result_t predict_bezout(logic [OPND_W-1:0] a,
			logic [OPND_W-1:0] b);
		bezout_result_t res;
		longint r0, r1, s0, s1, t0, t1, q, tmp, ca, cb, inv;
		bit a_div;
		int n;
		if (a == 0 || b == 0) begin
			res.gcd = '0;
			res.ca  = '0;
			res.cb  = '0;
			res.inv = '0;
			res.st  = STATUS_ZERO;
			return res;
		end
		a_div = a > b;
		r0 = a_div ? longint'(a) : longint'(b);
		r1 = a_div ? longint'(b) : longint'(a);
		s0 = 1; s1 = 0;
		t0 = 0; t1 = 1;
		n = 0;
		while (n < STEP_CAP && r1 != 0) begin
			q = r0 / r1;
			tmp = r0 - q * r1; r0 = r1; r1 = tmp;
			tmp = s0 - q * s1; s0 = s1; s1 = tmp;
			tmp = t0 - q * t1; t0 = t1; t1 = tmp;
			n++;
		end
		ca = a_div ? s0 : t0;
		cb = a_div ? t0 : s0;
		inv = ca < 0 ? ca + longint'(b) : ca;
		res.gcd = r0[OPND_W-1:0];
		res.ca  = ca[COEF_W-1:0];
		res.cb  = cb[COEF_W-1:0];
		res.inv = inv[OPND_W-1:0];
		res.st  = (r0 == 1) ? STATUS_OK : STATUS_NO_INV;
		return res;
	endfunction

	function automatic operand_pair_t random_pair();
		operand_pair_t p;
		logic [OPND_W-1:0] k, x;
		case ($urandom_range(19))
			0: begin
				p.a = $urandom_range(1) ? '0 : OPND_W'($urandom);
				p.b = (p.a != 0 || $urandom_range(1)) ? '0 : OPND_W'($urandom);
			end
			1, 2: begin
				p.a = OPND_W'($urandom_range(1, 100));
				p.b = OPND_W'($urandom_range(1, 100));
			end
			3, 4: begin
				k = OPND_W'($urandom_range(2, 1000));
				x = OPND_W'($urandom_range(1, 2000000));
				p.a = x * k;
				x = OPND_W'($urandom_range(1, 2000000));
				p.b = x * k;
			end
			5: begin
				p.a = OPND_W'($urandom);
				p.b = p.a;
			end
			6: begin
				k = OPND_W'($urandom_range(1, 20000));
				x = OPND_W'($urandom_range(1, 100000));
				if ($urandom_range(1)) begin
					p.a = x * k;
					p.b = x;
				end else begin
					p.a = x;
					p.b = x * k;
				end
			end
			default: begin
				p.a = OPND_W'($urandom);
				p.b = OPND_W'($urandom);
			end
		endcase
		return p;
	endfunction

	task automatic push_pair(logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
		operand_pair_t p;
		p.a = a;
		p.b = b;
		operand_q.push_back(p);
	endtask

	task automatic push_random(int count);
		repeat (count) operand_q.push_back(random_pair());
	endtask

	task automatic wait_drained();
		while (operand_q.size() != 0 || in_valid || bezout_expect_q.size() != 0)
			@(posedge clk);
	endtask

	// sender
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (operand_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				in_valid  <= 1'b1;
				operand_a <= operand_q[0].a;
				operand_b <= operand_q[0].b;
				operand_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with long hold-off on request
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_cnt = hold_req;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			out_stall <= 1'b1;
			hold_cnt--;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// input transfer capture and result checking
	always @(posedge clk) begin
		bezout_result_t e;
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			n_out++;
			if (bezout_expect_q.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				e = bezout_expect_q.pop_front();
				if (gcd_value !== e.gcd) begin
					$error("gcd_value: expected %0d, got %0d", e.gcd, gcd_value);
					errors++;
				end
				if (coef_a !== e.ca) begin
					$error("coef_a: expected %0d, got %0d", e.ca, coef_a);
					errors++;
				end
				if (coef_b !== e.cb) begin
					$error("coef_b: expected %0d, got %0d", e.cb, coef_b);
					errors++;
				end
				if (inverse !== e.inv) begin
					$error("inverse: expected %0d, got %0d", e.inv, inverse);
					errors++;
				end
				if (status !== e.st) begin
					$error("status: expected %0d, got %0d", e.st, status);
					errors++;
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			e = predict_bezout(operand_a, operand_b);
			bezout_expect_q.push_back(e);
			n_in++;
			case (e.st)
				STATUS_OK:     n_ok++;
				STATUS_NO_INV: n_no_inv++;
				default:       n_zero++;
			endcase
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, zero operands, equal, divisible, gcd not one, long chain
		push_pair(0, 0);
		push_pair(0, 5);
		push_pair(7, 0);
		push_pair(0, OPND_MAX);
		push_pair(OPND_MAX, 0);
		push_pair(OPND_MAX, OPND_MAX);
		push_pair(1, 1);
		push_pair(1, OPND_MAX);
		push_pair(OPND_MAX, 1);
		push_pair(3, 7);
		push_pair(7, 3);
		push_pair(12, 18);
		push_pair(5, 5);
		push_pair(6, 3);
		push_pair(3, 6);
		push_pair(1836311903, 1134903170);
		push_pair(1134903170, 1836311903);
		push_pair(OPND_MAX, OPND_MAX - OPND_W'(1));
		push_pair(2, OPND_MAX);
		push_pair(OPND_MAX - OPND_W'(1), 2);
		push_pair(31'h55555555, 31'h2AAAAAAA);
		push_pair(31'h40000000, 31'h3FFFFFFF);
		push_pair(31'h40000000, 31'h20000000);
		wait_drained();

		push_random(95);
		hold_req = 1500;
		wait_drained();

		sender_idle_pct = 55;
		push_random(95);
		wait_drained();

		sender_idle_pct = 0;
		receiver_stall_pct = 55;
		push_random(95);
		wait_drained();

		sender_idle_pct = 17;
		receiver_stall_pct = 17;
		push_random(95);
		wait_drained();

		repeat (300) @(posedge clk);
		$display("sent %0d operand pairs and checked %0d results", n_in, n_out);
		$display("  %0d invertible, %0d with gcd above one, %0d with a zero operand",
			n_ok, n_no_inv, n_zero);
		if (errors == 0 && bezout_expect_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
